// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds, so the consequent holds in the same cycle.
`define GBC_CHK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds, so the consequent holds in the next cycle.
`define GBC_CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gbc_pkg.sv -----
// ----------------------------------------------------------------------------
// gbc_pkg
// Types, widths and constants of the gyro bias calibrator.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int PROG_W     = 16;
    localparam int THR_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Sample and difference components are clamped to 2^21 before squaring.
    localparam int CLAMP_W   = 22;
    localparam int CLAMP_MAG = 1 << (CLAMP_W - 1);
    localparam int MAG_W     = (SAMPLE_W + 1 > CLAMP_W) ? SAMPLE_W + 1 : CLAMP_W;

    // Shared multiplier operand widths.
    localparam int MUL_A_W   = (SAMPLE_W > CLAMP_W) ? SAMPLE_W : CLAMP_W;
    localparam int MUL_B_W   = (CLAMP_W > PROG_W) ? CLAMP_W : PROG_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_TAG_W = 2;

    // Sum of three clamped squares stays below 2^(2*CLAMP_W).
    localparam int ACC_W = 2 * CLAMP_W;

    // Mean update: |mean*n + s| fits SAMPLE_W+16 bits, divisor n+1 needs 17.
    localparam int NMAG_W    = SAMPLE_W + PROG_W;
    localparam int NUM_W     = NMAG_W + 1;
    localparam int DEN_W     = PROG_W + 1;
    localparam int DIV_CNT_W = $clog2(SAMPLE_W + 1);

    localparam logic [PROG_W-1:0] PROG_MAX = {PROG_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TGT = 2'd2;

    localparam logic [THR_W-1:0]  STILL_THR_RST  = 20'd410;
    localparam logic [THR_W-1:0]  DEV_THR_RST    = 20'd2048;
    localparam logic [PROG_W-1:0] SAMPLE_TGT_RST = 16'd1000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] rate_x;
        logic signed [SAMPLE_W-1:0] rate_y;
        logic signed [SAMPLE_W-1:0] rate_z;
    } gbc_in_t;

    typedef struct packed {
        logic [PROG_W-1:0]          progress;
        logic                       already_done;
        logic signed [SAMPLE_W-1:0] bias_x;
        logic signed [SAMPLE_W-1:0] bias_y;
        logic signed [SAMPLE_W-1:0] bias_z;
    } gbc_out_t;

    typedef struct packed {
        logic                 valid;
        logic [MUL_TAG_W-1:0] tag;
    } gbc_mul_ctl_t;

    function automatic logic [CLAMP_W-1:0] clamp_mag(input logic signed [SAMPLE_W:0] v);
        logic [MAG_W-1:0] m;
        m = v[SAMPLE_W] ? MAG_W'(-v) : MAG_W'(v);
        if (m > MAG_W'(CLAMP_MAG))
            clamp_mag = CLAMP_W'(CLAMP_MAG);
        else
            clamp_mag = m[CLAMP_W-1:0];
    endfunction

endpackage

// ----- hdl/gbc_mul.sv -----
// ----------------------------------------------------------------------------
// gbc_mul
// Shared registered multiplier; the tag travels with the product.
// ----------------------------------------------------------------------------
module gbc_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gbc_pkg::gbc_mul_ctl_t        req,
    input  logic [gbc_pkg::MUL_A_W-1:0]  a,
    input  logic [gbc_pkg::MUL_B_W-1:0]  b,
    output gbc_pkg::gbc_mul_ctl_t        rsp,
    output logic [gbc_pkg::MUL_P_W-1:0]  p
);

    gbc_pkg::gbc_mul_ctl_t        rsp_reg;
    logic [gbc_pkg::MUL_P_W-1:0]  p_reg;
    logic [gbc_pkg::MUL_P_W-1:0]  p_next;

    assign p_next = gbc_pkg::MUL_P_W'(a) * gbc_pkg::MUL_P_W'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_reg <= '0;
        end
        else
        begin
            rsp_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            p_reg <= p_next;
        end
    end

    assign rsp = rsp_reg;
    assign p   = p_reg;

endmodule

// ----- hdl/gbc_div.sv -----
// ----------------------------------------------------------------------------
// gbc_div
// Restoring divider, one quotient bit per cycle, SAMPLE_W-bit quotient.
// ----------------------------------------------------------------------------
module gbc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gbc_pkg::NMAG_W-1:0]    dividend,
    input  logic [gbc_pkg::DEN_W-1:0]     divisor,
    output logic                          done,
    output logic [gbc_pkg::SAMPLE_W-1:0]  quotient
);

    localparam int SW = gbc_pkg::SAMPLE_W;
    localparam int DW = gbc_pkg::DEN_W;

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [gbc_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]                   rem_reg, rem_next;
    logic [DW-1:0]                   dsr_reg, dsr_next;
    logic [SW-1:0]                   quo_reg, quo_next;
    logic [DW+1:0]                   trial;
    logic                            borrow;

    // The quotient is known to fit SW bits, so the upper dividend bits
    // already form a partial remainder below the divisor.
    assign trial  = {1'b0, rem_reg, quo_reg[SW-1]} - {2'b00, dsr_reg};
    assign borrow = trial[DW+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = DW'(dividend[gbc_pkg::NMAG_W-1:SW]);
            quo_next  = dividend[SW-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = borrow ? {rem_reg[DW-2:0], quo_reg[SW-1]} : trial[DW-1:0];
            quo_next = {quo_reg[SW-2:0], ~borrow};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gbc_pkg::DIV_CNT_W'(SW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/gyro_bias_calibrator.sv -----
// ----------------------------------------------------------------------------
// gyro_bias_calibrator
// Running-mean gyro bias estimator with stillness and deviation tests.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  gbc_in_t  (rate_x, rate_y, rate_z)
//   out      source     out_valid/out_stall  gbc_out_t (progress, done flag, bias)
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction in gives one transaction out. A sample is worked on alone;
// the serial divider updates the three means one after the other. A first
// sample also runs the stillness test, and a finished block answers without
// a new update. The squared-norm tests share one registered multiplier.
// Reset clears the mean, the counter and the registers to their defaults.
// The next sample is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  gbc_pkg::gbc_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output gbc_pkg::gbc_out_t                out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SW = gbc_pkg::SAMPLE_W;
    localparam int PW = gbc_pkg::PROG_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SQ_ISSUE = 3'd1;
    localparam logic [2:0] S_SQ_DRAIN = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_UP_MUL   = 3'd4;
    localparam logic [2:0] S_UP_NUM   = 3'd5;
    localparam logic [2:0] S_UP_DIV   = 3'd6;
    localparam logic [2:0] S_RESULT   = 3'd7;

    localparam logic [gbc_pkg::MUL_TAG_W-1:0] TAG_THR  = 2'd3;
    localparam logic [1:0]                    AXIS_Z   = 2'd2;

    logic [2:0]                        state_reg, state_next;
    logic [1:0]                        step_reg, step_next;
    logic [1:0]                        axis_reg, axis_next;
    logic                              dev_phase_reg, dev_phase_next;
    logic [gbc_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic [gbc_pkg::ACC_W-1:0]         thr_sq_reg, thr_sq_next;
    logic signed [SW-1:0]              samp_x_reg, samp_x_next;
    logic signed [SW-1:0]              samp_y_reg, samp_y_next;
    logic signed [SW-1:0]              samp_z_reg, samp_z_next;
    logic signed [SW-1:0]              mean_x_reg, mean_x_next;
    logic signed [SW-1:0]              mean_y_reg, mean_y_next;
    logic signed [SW-1:0]              mean_z_reg, mean_z_next;
    logic [PW-1:0]                     count_reg, count_next;
    logic                              finished_reg, finished_next;
    logic [PW-1:0]                     res_prog_reg, res_prog_next;
    logic                              res_done_reg, res_done_next;
    logic                              num_neg_reg, num_neg_next;
    logic                              out_valid_reg, out_valid_next;
    gbc_pkg::gbc_out_t                 out_data_reg, out_data_next;
    logic [gbc_pkg::THR_W-1:0]         still_thr_reg, still_thr_next;
    logic [gbc_pkg::THR_W-1:0]         dev_thr_reg, dev_thr_next;
    logic [PW-1:0]                     target_reg, target_next;

    logic [1:0]                        sel_idx;
    logic signed [SW-1:0]              mean_sel;
    logic signed [SW-1:0]              samp_sel;
    logic signed [SW:0]                diff;
    logic signed [SW:0]                sq_src;
    logic [gbc_pkg::CLAMP_W-1:0]       sq_mag;
    logic [gbc_pkg::THR_W-1:0]         thr_sel;
    logic [SW-1:0]                     mean_abs;
    logic [gbc_pkg::DEN_W-1:0]         cnt_plus1;
    logic [gbc_pkg::NUM_W-1:0]         prod_ext;
    logic signed [gbc_pkg::NUM_W-1:0]  prod_s;
    logic signed [gbc_pkg::NUM_W-1:0]  num_s;
    logic [gbc_pkg::NMAG_W-1:0]        num_abs;
    logic signed [SW-1:0]              new_mean;

    gbc_pkg::gbc_mul_ctl_t             mul_req;
    gbc_pkg::gbc_mul_ctl_t             mul_rsp;
    logic [gbc_pkg::MUL_A_W-1:0]       mul_a;
    logic [gbc_pkg::MUL_B_W-1:0]       mul_b;
    logic [gbc_pkg::MUL_P_W-1:0]       mul_p;

    logic                              div_start;
    logic [gbc_pkg::NMAG_W-1:0]        div_dividend;
    logic [gbc_pkg::DEN_W-1:0]         div_divisor;
    logic                              div_done;
    logic [SW-1:0]                     div_quot;

    gbc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a     (mul_a),
        .b     (mul_b),
        .rsp   (mul_rsp),
        .p     (mul_p)
    );

    gbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // One axis is selected at a time: by the square step or by the update axis.
    assign sel_idx = (state_reg == S_SQ_ISSUE) ? step_reg : axis_reg;

    always_comb
    begin
        case (sel_idx)
            2'd0:
            begin
                mean_sel = mean_x_reg;
                samp_sel = samp_x_reg;
            end
            2'd1:
            begin
                mean_sel = mean_y_reg;
                samp_sel = samp_y_reg;
            end
            default:
            begin
                mean_sel = mean_z_reg;
                samp_sel = samp_z_reg;
            end
        endcase
    end

    assign diff      = {mean_sel[SW-1], mean_sel} - {samp_sel[SW-1], samp_sel};
    assign sq_src    = dev_phase_reg ? diff : {samp_sel[SW-1], samp_sel};
    assign sq_mag    = gbc_pkg::clamp_mag(sq_src);
    assign thr_sel   = dev_phase_reg ? dev_thr_reg : still_thr_reg;
    assign mean_abs  = mean_sel[SW-1] ? SW'(-mean_sel) : mean_sel;
    assign cnt_plus1 = {1'b0, count_reg} + 1'b1;

    // mean*n + sample, then split into sign and magnitude for the divider.
    assign prod_ext = gbc_pkg::NUM_W'(mul_p[gbc_pkg::NMAG_W-1:0]);
    assign prod_s   = mean_sel[SW-1] ? -$signed(prod_ext) : $signed(prod_ext);
    assign num_s    = prod_s + gbc_pkg::NUM_W'(samp_sel);
    assign num_abs  = num_s[gbc_pkg::NUM_W-1] ? gbc_pkg::NMAG_W'(-num_s)
                                              : gbc_pkg::NMAG_W'(num_s);
    assign new_mean = num_neg_reg ? SW'(-div_quot) : div_quot;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        axis_next      = axis_reg;
        dev_phase_next = dev_phase_reg;
        acc_next       = acc_reg;
        thr_sq_next    = thr_sq_reg;
        samp_x_next    = samp_x_reg;
        samp_y_next    = samp_y_reg;
        samp_z_next    = samp_z_reg;
        mean_x_next    = mean_x_reg;
        mean_y_next    = mean_y_reg;
        mean_z_next    = mean_z_reg;
        count_next     = count_reg;
        finished_next  = finished_reg;
        res_prog_next  = res_prog_reg;
        res_done_next  = res_done_reg;
        num_neg_next   = num_neg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        still_thr_next = still_thr_reg;
        dev_thr_next   = dev_thr_reg;
        target_next    = target_reg;
        mul_req        = '0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                gbc_pkg::CFG_STILL_THR:  still_thr_next = cfg_data[gbc_pkg::THR_W-1:0];
                gbc_pkg::CFG_DEV_THR:    dev_thr_next   = cfg_data[gbc_pkg::THR_W-1:0];
                gbc_pkg::CFG_SAMPLE_TGT: target_next    = cfg_data[PW-1:0];
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Products of the norm pass arrive in the cycle after issue.
        if (mul_rsp.valid && (state_reg == S_SQ_ISSUE || state_reg == S_SQ_DRAIN))
        begin
            if (mul_rsp.tag == TAG_THR)
                thr_sq_next = mul_p[gbc_pkg::ACC_W-1:0];
            else
                acc_next = acc_reg + mul_p[gbc_pkg::ACC_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    samp_x_next = in_data.rate_x;
                    samp_y_next = in_data.rate_y;
                    samp_z_next = in_data.rate_z;
                    if (finished_reg)
                    begin
                        res_prog_next = gbc_pkg::PROG_MAX;
                        res_done_next = 1'b1;
                        state_next    = S_RESULT;
                    end
                    else
                    begin
                        res_done_next  = 1'b0;
                        dev_phase_next = (count_reg != '0);
                        acc_next       = '0;
                        step_next      = '0;
                        state_next     = S_SQ_ISSUE;
                    end
                end
            end
            S_SQ_ISSUE:
            begin
                mul_req.valid = 1'b1;
                mul_req.tag   = step_reg;
                if (step_reg == TAG_THR)
                begin
                    mul_a      = gbc_pkg::MUL_A_W'(thr_sel);
                    mul_b      = gbc_pkg::MUL_B_W'(thr_sel);
                    state_next = S_SQ_DRAIN;
                end
                else
                begin
                    mul_a     = gbc_pkg::MUL_A_W'(sq_mag);
                    mul_b     = gbc_pkg::MUL_B_W'(sq_mag);
                    step_next = step_reg + 1'b1;
                end
            end
            S_SQ_DRAIN:
            begin
                if (mul_rsp.valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!dev_phase_reg)
                begin
                    // A still first sample joins the mean without the deviation test.
                    if (acc_reg < thr_sq_reg)
                    begin
                        axis_next  = '0;
                        state_next = S_UP_MUL;
                    end
                    else
                    begin
                        dev_phase_next = 1'b1;
                        acc_next       = '0;
                        step_next      = '0;
                        state_next     = S_SQ_ISSUE;
                    end
                end
                else if (acc_reg > thr_sq_reg)
                begin
                    mean_x_next   = '0;
                    mean_y_next   = '0;
                    mean_z_next   = '0;
                    count_next    = '0;
                    res_prog_next = '0;
                    state_next    = S_RESULT;
                end
                else
                begin
                    axis_next  = '0;
                    state_next = S_UP_MUL;
                end
            end
            S_UP_MUL:
            begin
                mul_req.valid = 1'b1;
                mul_a         = gbc_pkg::MUL_A_W'(mean_abs);
                mul_b         = gbc_pkg::MUL_B_W'(count_reg);
                state_next    = S_UP_NUM;
            end
            S_UP_NUM:
            begin
                div_start    = 1'b1;
                div_dividend = num_abs;
                div_divisor  = cnt_plus1;
                num_neg_next = num_s[gbc_pkg::NUM_W-1];
                state_next   = S_UP_DIV;
            end
            S_UP_DIV:
            begin
                if (div_done)
                begin
                    case (axis_reg)
                        2'd0:    mean_x_next = new_mean;
                        2'd1:    mean_y_next = new_mean;
                        default: mean_z_next = new_mean;
                    endcase
                    if (axis_reg == AXIS_Z)
                    begin
                        count_next    = cnt_plus1[PW-1:0];
                        res_prog_next = cnt_plus1[PW-1:0];
                        // The counter never wraps: reaching its top also ends the run.
                        if (cnt_plus1 > {1'b0, target_reg} ||
                            cnt_plus1 >= {1'b0, gbc_pkg::PROG_MAX})
                            finished_next = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_UP_MUL;
                    end
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.progress     = res_prog_reg;
                    out_data_next.already_done = res_done_reg;
                    out_data_next.bias_x       = mean_x_reg;
                    out_data_next.bias_y       = mean_y_reg;
                    out_data_next.bias_z       = mean_z_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            axis_reg      <= '0;
            dev_phase_reg <= 1'b0;
            mean_x_reg    <= '0;
            mean_y_reg    <= '0;
            mean_z_reg    <= '0;
            count_reg     <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            still_thr_reg <= gbc_pkg::STILL_THR_RST;
            dev_thr_reg   <= gbc_pkg::DEV_THR_RST;
            target_reg    <= gbc_pkg::SAMPLE_TGT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            axis_reg      <= axis_next;
            dev_phase_reg <= dev_phase_next;
            mean_x_reg    <= mean_x_next;
            mean_y_reg    <= mean_y_next;
            mean_z_reg    <= mean_z_next;
            count_reg     <= count_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
            still_thr_reg <= still_thr_next;
            dev_thr_reg   <= dev_thr_next;
            target_reg    <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        thr_sq_reg   <= thr_sq_next;
        samp_x_reg   <= samp_x_next;
        samp_y_reg   <= samp_y_next;
        samp_z_reg   <= samp_z_next;
        res_prog_reg <= res_prog_next;
        res_done_reg <= res_done_next;
        num_neg_reg  <= num_neg_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ----- hdl/gbc_checker.sv -----
// ----------------------------------------------------------------------------
// gbc_checker
// Port-level assertions for the gyro bias calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input gbc_pkg::gbc_out_t out_data
);

    // A stalled result transaction keeps its payload.
    `GBC_CHK_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "out held payload changed")

    // One sample at a time: the input stalls right after a transaction.
    `GBC_CHK_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled while busy")

    // A finished block reports the saturated progress value.
    `GBC_CHK_IMP(a_done_progress, out_valid && out_data.already_done, out_data.progress == gbc_pkg::PROG_MAX, "done result with wrong progress")

    // Progress zero only comes from a restart, which clears the bias.
    `GBC_CHK_IMP(a_restart_zero, out_valid && !out_data.already_done && out_data.progress == '0, out_data.bias_x == '0 && out_data.bias_y == '0 && out_data.bias_z == '0, "restart with nonzero bias")

endmodule

bind gyro_bias_calibrator gbc_checker u_gbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
